@@ sv/fvc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the formation velocity command block.
// Used by formation_velocity_command and fvc_checker; no dependencies.
package fvc_pkg;

   localparam int POS_W          = 16;
   localparam int FWD_W          = 15;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int ANGLE_BITS_DEF = 16;

   // Quarter-wave sine polynomial, Q2.30
   localparam logic signed [32:0] ONE30 = 33'sh040000000;
   localparam logic signed [32:0] SC1   = 33'sd1686629713;
   localparam logic signed [32:0] SC3   = 33'sd693598668;
   localparam logic signed [32:0] SC5   = 33'sd85569305;
   localparam logic signed [32:0] SC7   = 33'sd5026995;
   localparam logic signed [32:0] SC9   = 33'sd172272;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN,
      CSR_BACK_OFFSET,
      CSR_LEFT_OFFSET,
      CSR_KEEP_DISTANCE,
      CSR_MAX_SPEED,
      CSR_MAX_TURN,
      CSR_OFFSET_RECIP
   } csr_index_type;

   // Trig unit slots: 0 leader sin, 1 leader cos, 2 own sin, 3 own cos
   typedef struct packed {
      logic                cmd;
      logic signed [16:0]  dx;
      logic signed [16:0]  dy;
      logic [3:0][30:0]    z;
      logic [3:0]          neg;
      logic [3:0][30:0]    z2;
      logic [3:0][32:0]    p;
      logic [3:0][31:0]    trig;
      logic [33:0]         dxx;
      logic [33:0]         dyy;
      logic [33:0]         nsq;
      logic [19:0]         sq_rem;
      logic [16:0]         root;
      logic [3:0][47:0]    mp;
      logic signed [23:0]  ex0;
      logic signed [23:0]  ey0;
      logic [31:0]         numx;
      logic [31:0]         numy;
      logic [16:0]         remx;
      logic [16:0]         remy;
      logic [15:0]         qx;
      logic [15:0]         qy;
      logic signed [15:0]  ex;
      logic signed [15:0]  ey;
      logic signed [31:0]  gx;
      logic signed [31:0]  gy;
      logic signed [31:0]  vx;
      logic signed [31:0]  vy;
      logic [3:0][63:0]    rp;
      logic signed [31:0]  fwd;
      logic signed [31:0]  lat;
      logic signed [63:0]  po;
      logic [14:0]         fwd_out;
      logic signed [15:0]  om_out;
   } item_type;

   // Horner coefficient for step 0..3
   function automatic logic signed [32:0] hcoef(input int step);
      case (step)
         0:       hcoef = SC7;
         1:       hcoef = SC5;
         2:       hcoef = SC3;
         default: hcoef = SC1;
      endcase
   endfunction

   // Right shift with rounding half away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int n);
      logic [63:0] mag;
      logic [63:0] half;
      half = 64'd1 << (n - 1);
      mag  = v[63] ? (64'd0 - unsigned'(v)) : unsigned'(v);
      mag  = (mag + half) >> n;
      rnd_shr = v[63] ? $signed(64'd0 - mag) : $signed(mag);
   endfunction

   // Saturate to 16 bits signed
   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      if (v > 24'sd32767)
         sat16 = 16'sh7fff;
      else if (v < -24'sd32768)
         sat16 = 16'sh8000;
      else
         sat16 = v[15:0];
   endfunction

endpackage

@@ sv/formation_velocity_command.sv @@
// Formation velocity command: pipelined leader-follower P controller.
// Depends on fvc_pkg.
//
// Usage:
//   Input channel req_*: one pose pair per transfer (leader and own pose, mode bit).
//   Output channel rsp_*: one velocity command per input, in order, with the
//   saturated global position error that produced it.
//   Configuration csr_*: write-only registers, to be written while the block is idle; the block does not enforce this.
// Timing:
//   44 register stages: the result is driven from the last stage register. One item
//   is accepted every cycle while req_stall is low; the depth is set by the 17-step
//   square-root and 16-step divider stages of distance mode.
// Reset:
//   Synchronous reset empties the pipeline and loads register defaults.
// Stall:
//   Each stage holds while its successor is full and blocked. Empty stages keep
//   filling, so req_stall rises only once every stage holds an item and rsp_stall
//   is high.
module formation_velocity_command
   import fvc_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic signed [POS_W-1:0]      req_leader_x,
   input  logic signed [POS_W-1:0]      req_leader_y,
   input  logic signed [POS_W-1:0]      req_leader_heading,
   input  logic signed [POS_W-1:0]      req_self_x,
   input  logic signed [POS_W-1:0]      req_self_y,
   input  logic signed [POS_W-1:0]      req_self_heading,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [FWD_W-1:0]             rsp_forward_speed,
   output logic signed [POS_W-1:0]      rsp_turn_rate,
   output logic signed [POS_W-1:0]      rsp_error_x,
   output logic signed [POS_W-1:0]      rsp_error_y,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int ST_SQ    = 1;
   localparam int ST_H1    = 2;
   localparam int ST_H4    = 5;
   localparam int ST_TZ    = 6;
   localparam int ST_M0P   = 7;
   localparam int ST_M0S   = 8;
   localparam int SQ_FIRST = 3;
   localparam int SQ_STEPS = 17;
   localparam int ST_DIVN  = SQ_FIRST + SQ_STEPS;
   localparam int DV_FIRST = ST_DIVN + 1;
   localparam int DV_STEPS = 16;
   localparam int ST_SEL   = DV_FIRST + DV_STEPS;
   localparam int ST_GAIN  = ST_SEL + 1;
   localparam int ST_VEL   = ST_GAIN + 1;
   localparam int ST_ROT   = ST_VEL + 1;
   localparam int ST_ROTS  = ST_ROT + 1;
   localparam int ST_OMP   = ST_ROTS + 1;
   localparam int ST_OUT   = ST_OMP + 1;
   localparam int DEPTH    = ST_OUT + 1;

   localparam logic [ANGLE_BITS-1:0] ANG_QTR = {2'b01, {(ANGLE_BITS-2){1'b0}}};

   // Configuration registers
   logic [14:0]        gain_ff;
   logic signed [15:0] back_off_ff;
   logic signed [15:0] left_off_ff;
   logic [14:0]        keep_ff;
   logic [14:0]        max_speed_ff;
   logic [14:0]        max_turn_ff;
   logic [15:0]        orec_ff;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= 15'd4096;
         back_off_ff  <= 16'sd1638;
         left_off_ff  <= 16'sd2867;
         keep_ff      <= 15'd3277;
         max_speed_ff <= 15'd2048;
         max_turn_ff  <= 15'd7373;
         orec_ff      <= 16'd20480;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN:          gain_ff      <= csr_wdata[14:0];
            CSR_BACK_OFFSET:   back_off_ff  <= $signed(csr_wdata);
            CSR_LEFT_OFFSET:   left_off_ff  <= $signed(csr_wdata);
            CSR_KEEP_DISTANCE: keep_ff      <= csr_wdata[14:0];
            CSR_MAX_SPEED:     max_speed_ff <= csr_wdata[14:0];
            CSR_MAX_TURN:      max_turn_ff  <= csr_wdata[14:0];
            CSR_OFFSET_RECIP:  orec_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Rescale headings to angle units; slots follow item_type trig order
   logic [ANGLE_BITS+15:0] lwide;
   logic [ANGLE_BITS+15:0] swide;
   logic [ANGLE_BITS-1:0]  ang [4];

   assign lwide  = {req_leader_heading, {ANGLE_BITS{1'b0}}};
   assign swide  = {req_self_heading, {ANGLE_BITS{1'b0}}};
   assign ang[0] = lwide[ANGLE_BITS+15:16];
   assign ang[1] = lwide[ANGLE_BITS+15:16] + ANG_QTR;
   assign ang[2] = swide[ANGLE_BITS+15:16];
   assign ang[3] = swide[ANGLE_BITS+15:16] + ANG_QTR;

   item_type in_item;

   // Build the entry item: differences and quarter-wave folding
   always_comb begin
      logic [29:0] zfr;
      logic [30:0] zq;
      in_item     = '0;
      in_item.cmd = req_command;
      in_item.dx  = 17'(req_leader_x) - 17'(req_self_x);
      in_item.dy  = 17'(req_leader_y) - 17'(req_self_y);
      for (int i = 0; i < 4; i++) begin
         zfr = {ang[i][ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
         zq  = {1'b0, zfr};
         if (ang[i][ANGLE_BITS-2])
            zq = 31'(unsigned'(ONE30)) - zq;
         in_item.z[i]   = zq;
         in_item.neg[i] = ang[i][ANGLE_BITS-1];
      end
   end

   item_type pipe_ff [DEPTH];
   item_type pipe_in [DEPTH];
   item_type stage_src [DEPTH];
   logic     valid_ff [DEPTH];
   logic     adv [DEPTH];

   // Advance a stage when it is empty or its successor advances
   assign adv[DEPTH-1] = !valid_ff[DEPTH-1] || !rsp_stall;
   for (genvar k = 0; k < DEPTH - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign req_stall = !adv[0];

   for (genvar k = 0; k < DEPTH; k++) begin : g_stage
      localparam int HS = (k >= ST_H1 && k <= ST_H4) ? k - ST_H1 : 0;
      localparam int SJ = (k >= SQ_FIRST && k < SQ_FIRST + SQ_STEPS) ? k - SQ_FIRST : 0;
      localparam int DI = (k >= DV_FIRST && k < DV_FIRST + DV_STEPS) ? k - DV_FIRST : 0;

      if (k == 0) begin : g_first
         assign stage_src[k] = in_item;
      end else begin : g_next
         assign stage_src[k] = pipe_ff[k-1];
      end

      // Stage datapath
      always_comb begin
         logic signed [64:0] ma;
         logic signed [64:0] mb;
         logic signed [64:0] mp;
         logic signed [63:0] sa;
         logic signed [63:0] rv;
         logic signed [63:0] lim;
         logic [19:0]        rsh;
         logic [19:0]        trial;
         logic [17:0]        dsh;
         logic [17:0]        dref;
         logic [16:0]        absd;
         logic signed [23:0] exw;
         logic signed [23:0] eyw;
         item_type           prev;
         prev  = stage_src[k];
         pipe_in[k] = prev;
         ma = '0; mb = '0; mp = '0; sa = '0; rv = '0; lim = '0;
         rsh = '0; trial = '0; dsh = '0; dref = '0; absd = '0; exw = '0; eyw = '0;

         // Squares of the quarter fractions and of the differences
         if (k == ST_SQ) begin
            for (int i = 0; i < 4; i++) begin
               ma = 65'($signed({1'b0, prev.z[i]}));
               mp = ma * ma;
               pipe_in[k].z2[i] = mp[60:30];
            end
            sa = 64'(prev.dx);
            sa = sa * sa;
            pipe_in[k].dxx = sa[33:0];
            sa = 64'(prev.dy);
            sa = sa * sa;
            pipe_in[k].dyy = sa[33:0];
         end

         // Horner steps of the sine polynomial in z squared
         if (k >= ST_H1 && k <= ST_H4) begin
            for (int i = 0; i < 4; i++) begin
               ma = (k == ST_H1) ? 65'(SC9) : 65'($signed(prev.p[i]));
               mb = 65'($signed({1'b0, prev.z2[i]}));
               mp = 65'(hcoef(HS)) - ((ma * mb) >>> 30);
               pipe_in[k].p[i] = mp[32:0];
            end
         end
         if (k == ST_H1) begin
            pipe_in[k].nsq    = prev.dxx + prev.dyy;
            pipe_in[k].sq_rem = '0;
            pipe_in[k].root   = '0;
         end

         // Final multiply by z, clamp to one, apply quadrant sign
         if (k == ST_TZ) begin
            for (int i = 0; i < 4; i++) begin
               ma = 65'($signed(prev.p[i]));
               mb = 65'($signed({1'b0, prev.z[i]}));
               mp = (ma * mb) >>> 30;
               if (mp > 65'(ONE30))
                  mp = 65'(ONE30);
               if (prev.neg[i])
                  mp = -mp;
               pipe_in[k].trig[i] = mp[31:0];
            end
         end

         // Offset point: rotate the offsets by the leader heading
         if (k == ST_M0P) begin
            sa = 64'($signed(prev.trig[1])) * 64'(back_off_ff);
            pipe_in[k].mp[0] = sa[47:0];
            sa = 64'($signed(prev.trig[0])) * 64'(left_off_ff);
            pipe_in[k].mp[1] = sa[47:0];
            sa = 64'($signed(prev.trig[0])) * 64'(back_off_ff);
            pipe_in[k].mp[2] = sa[47:0];
            sa = 64'($signed(prev.trig[1])) * 64'(left_off_ff);
            pipe_in[k].mp[3] = sa[47:0];
         end
         if (k == ST_M0S) begin
            sa = -64'($signed(prev.mp[0])) - 64'($signed(prev.mp[1]));
            rv = rnd_shr(sa, 30);
            pipe_in[k].ex0 = 24'(prev.dx) + $signed(rv[23:0]);
            sa = 64'($signed(prev.mp[3])) - 64'($signed(prev.mp[2]));
            rv = rnd_shr(sa, 30);
            pipe_in[k].ey0 = 24'(prev.dy) + $signed(rv[23:0]);
         end

         // Range: one root bit per stage
         if (k >= SQ_FIRST && k < SQ_FIRST + SQ_STEPS) begin
            rsh   = {prev.sq_rem[17:0], prev.nsq[33-2*SJ -: 2]};
            trial = {1'b0, prev.root, 2'b01};
            if (rsh >= trial) begin
               pipe_in[k].sq_rem = rsh - trial;
               pipe_in[k].root   = {prev.root[15:0], 1'b1};
            end else begin
               pipe_in[k].sq_rem = rsh;
               pipe_in[k].root   = {prev.root[15:0], 1'b0};
            end
         end

         // Dividend of the spacing correction, rounded by half the range
         if (k == ST_DIVN) begin
            absd = prev.dx[16] ? 17'(-prev.dx) : prev.dx;
            pipe_in[k].numx = {17'b0, keep_ff} * {15'b0, absd} + {16'b0, prev.root[16:1]};
            absd = prev.dy[16] ? 17'(-prev.dy) : prev.dy;
            pipe_in[k].numy = {17'b0, keep_ff} * {15'b0, absd} + {16'b0, prev.root[16:1]};
            pipe_in[k].remx = {1'b0, pipe_in[k].numx[31:16]};
            pipe_in[k].remy = {1'b0, pipe_in[k].numy[31:16]};
            pipe_in[k].qx   = '0;
            pipe_in[k].qy   = '0;
         end

         // Restoring divide by the range: one quotient bit per stage
         if (k >= DV_FIRST && k < DV_FIRST + DV_STEPS) begin
            dref = {1'b0, prev.root};
            dsh  = {prev.remx, prev.numx[15-DI]};
            if (dsh >= dref) begin
               pipe_in[k].remx       = 17'(dsh - dref);
               pipe_in[k].qx[15-DI]  = 1'b1;
            end else begin
               pipe_in[k].remx       = dsh[16:0];
            end
            dsh = {prev.remy, prev.numy[15-DI]};
            if (dsh >= dref) begin
               pipe_in[k].remy       = 17'(dsh - dref);
               pipe_in[k].qy[15-DI]  = 1'b1;
            end else begin
               pipe_in[k].remy       = dsh[16:0];
            end
         end

         // Select the mode error and saturate
         if (k == ST_SEL) begin
            if (!prev.cmd) begin
               exw = prev.ex0;
               eyw = prev.ey0;
            end else if (prev.root == '0) begin
               exw = -$signed({9'b0, keep_ff});
               eyw = '0;
            end else begin
               exw = prev.dx[16] ? 24'(prev.dx) + $signed({8'b0, prev.qx})
                                 : 24'(prev.dx) - $signed({8'b0, prev.qx});
               eyw = prev.dy[16] ? 24'(prev.dy) + $signed({8'b0, prev.qy})
                                 : 24'(prev.dy) - $signed({8'b0, prev.qy});
            end
            pipe_in[k].ex = sat16(exw);
            pipe_in[k].ey = sat16(eyw);
         end

         // Apply the gain
         if (k == ST_GAIN) begin
            pipe_in[k].gx = $signed({1'b0, gain_ff}) * 32'(prev.ex);
            pipe_in[k].gy = $signed({1'b0, gain_ff}) * 32'(prev.ey);
         end
         if (k == ST_VEL) begin
            rv = rnd_shr(64'(prev.gx), FRAC_BITS);
            pipe_in[k].vx = rv[31:0];
            rv = rnd_shr(64'(prev.gy), FRAC_BITS);
            pipe_in[k].vy = rv[31:0];
         end

         // Rotate the global velocity into the vehicle frame
         if (k == ST_ROT) begin
            pipe_in[k].rp[0] = 64'($signed(prev.trig[3])) * 64'(prev.vx);
            pipe_in[k].rp[1] = 64'($signed(prev.trig[2])) * 64'(prev.vy);
            pipe_in[k].rp[2] = 64'($signed(prev.trig[2])) * 64'(prev.vx);
            pipe_in[k].rp[3] = 64'($signed(prev.trig[3])) * 64'(prev.vy);
         end
         if (k == ST_ROTS) begin
            rv = rnd_shr($signed(prev.rp[0]) + $signed(prev.rp[1]), 30);
            pipe_in[k].fwd = rv[31:0];
            rv = rnd_shr($signed(prev.rp[3]) - $signed(prev.rp[2]), 30);
            pipe_in[k].lat = rv[31:0];
         end

         // Turn rate from lateral speed
         if (k == ST_OMP) begin
            pipe_in[k].po = 64'(prev.lat) * 64'($signed({1'b0, orec_ff}));
         end

         // Clamp both commands
         if (k == ST_OUT) begin
            rv  = rnd_shr(prev.po, FRAC_BITS);
            lim = 64'($signed({1'b0, max_turn_ff}));
            if (rv > lim)
               rv = lim;
            else if (rv < -lim)
               rv = -lim;
            pipe_in[k].om_out = rv[15:0];
            sa  = 64'(prev.fwd);
            lim = 64'($signed({1'b0, max_speed_ff}));
            if (sa > lim)
               sa = lim;
            else if (sa < 0)
               sa = '0;
            pipe_in[k].fwd_out = sa[14:0];
         end
      end

      // Stage registers: load on advance
      always_ff @(posedge clock) begin
         if (adv[k])
            pipe_ff[k] <= pipe_in[k];
      end

      always_ff @(posedge clock) begin
         if (reset)
            valid_ff[k] <= 1'b0;
         else if (adv[k])
            valid_ff[k] <= (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // Drive the result channel from the last stage
   assign rsp_valid         = valid_ff[DEPTH-1];
   assign rsp_forward_speed = pipe_ff[DEPTH-1].fwd_out;
   assign rsp_turn_rate     = pipe_ff[DEPTH-1].om_out;
   assign rsp_error_x       = pipe_ff[DEPTH-1].ex;
   assign rsp_error_y       = pipe_ff[DEPTH-1].ey;

endmodule

@@ sv/fvc_checker.sv @@
// Port-level checks for formation_velocity_command, attached by bind.
// Depends on fvc_pkg.
module fvc_checker
   import fvc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [FWD_W-1:0]        rsp_forward_speed,
   input logic signed [POS_W-1:0] rsp_turn_rate,
   input logic signed [POS_W-1:0] rsp_error_x,
   input logic signed [POS_W-1:0] rsp_error_y
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input stalls only when the pipeline is full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // Hold a stalled result
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_forward_speed) && $stable(rsp_turn_rate)
                                    && $stable(rsp_error_x) && $stable(rsp_error_y)))
      else $error("stalled result changed");

endmodule

bind formation_velocity_command fvc_checker u_fvc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_forward_speed (rsp_forward_speed),
   .rsp_turn_rate     (rsp_turn_rate),
   .rsp_error_x       (rsp_error_x),
   .rsp_error_y       (rsp_error_y)
);

@@ test/tb_formation_velocity_command.sv @@
// Self-checking bench for formation_velocity_command: random and directed pose pairs,
// bit-exact command predictor, in-order compare. Depends on fvc_pkg and the block.
`timescale 1ns / 1ps

module tb_formation_velocity_command;
   import fvc_pkg::*;

   typedef struct {
      logic               cmd;
      logic signed [15:0] lx, ly, lh, sx, sy, sh;
   } pose_pair_type;

   typedef struct {
      logic [14:0]        fwd;
      logic signed [15:0] om;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
   } vel_cmd_type;

   localparam longint Q30 = 64'sd1 << 30;
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;

   // Command predictor and in-order store of pending commands
   class fvc_scoreboard;
      longint gain, back_off, left_off, keep_dist, max_spd, max_trn, recip;
      vel_cmd_type pending_cmds[$];
      int fails;
      int n_checked;

      function new();
         gain = 4096; back_off = 1638; left_off = 2867; keep_dist = 3277;
         max_spd = 2048; max_trn = 7373; recip = 20480;
         fails = 0; n_checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_GAIN:          gain = longint'(v[14:0]);
            CSR_BACK_OFFSET:   back_off = longint'($signed(v));
            CSR_LEFT_OFFSET:   left_off = longint'($signed(v));
            CSR_KEEP_DISTANCE: keep_dist = longint'(v[14:0]);
            CSR_MAX_SPEED:     max_spd = longint'(v[14:0]);
            CSR_MAX_TURN:      max_trn = longint'(v[14:0]);
            CSR_OFFSET_RECIP:  recip = longint'(v);
            default: ;
         endcase
      endfunction

      function longint round_shr(longint v, int n);
         longint half;
         half = 64'sd1 <<< (n - 1);
         if (v >= 0) return (v + half) >>> n;
         return -((-v + half) >>> n);
      endfunction

      function longint sat_16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint quarter_wave(longint z);
         longint z2, p;
         z2 = (z * z) >>> 30;
         p = 64'sd172272;
         p = 64'sd5026995 - ((p * z2) >>> 30);
         p = 64'sd85569305 - ((p * z2) >>> 30);
         p = 64'sd693598668 - ((p * z2) >>> 30);
         p = 64'sd1686629713 - ((p * z2) >>> 30);
         p = (p * z) >>> 30;
         return (p > Q30) ? Q30 : p;
      endfunction

      function longint sine(int unsigned u);
         int unsigned q, r;
         longint z, s;
         u = u & 32'hFFFF;
         q = u >> 14;
         r = u & 32'h3FFF;
         z = longint'(r) << 16;
         if (q & 1) z = Q30 - z;
         s = quarter_wave(z);
         return (q & 2) ? -s : s;
      endfunction

      function longint cosine(int unsigned u);
         return sine(u + 16384);
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint spacing_share(longint d, longint v, longint unsigned r);
         longint unsigned m, q;
         m = (v < 0) ? longint'(-v) : longint'(v);
         q = (longint'(d) * m + r / 2) / r;
         return (v < 0) ? -longint'(q) : longint'(q);
      endfunction

      function vel_cmd_type compute_command(pose_pair_type p);
         vel_cmd_type o;
         longint lx, ly, sx, sy, ex, ey, vx, vy, c, s, fwd, lat, om, dx, dy;
         longint unsigned r;
         lx = p.lx; ly = p.ly; sx = p.sx; sy = p.sy;
         if (!p.cmd) begin
            c = cosine(int'(unsigned'(p.lh)));
            s = sine(int'(unsigned'(p.lh)));
            ex = lx + round_shr(-c * back_off - s * left_off, 30) - sx;
            ey = ly + round_shr(-s * back_off + c * left_off, 30) - sy;
         end else begin
            dx = lx - sx;
            dy = ly - sy;
            r = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
            // coincident poses: line angle taken as zero
            if (r == 0) begin
               ex = -keep_dist;
               ey = 0;
            end else begin
               ex = dx - spacing_share(keep_dist, dx, r);
               ey = dy - spacing_share(keep_dist, dy, r);
            end
         end
         ex = sat_16(ex);
         ey = sat_16(ey);
         vx = round_shr(gain * ex, 12);
         vy = round_shr(gain * ey, 12);
         c = cosine(int'(unsigned'(p.sh)));
         s = sine(int'(unsigned'(p.sh)));
         fwd = round_shr(c * vx + s * vy, 30);
         lat = round_shr(-s * vx + c * vy, 30);
         om = round_shr(lat * recip, 12);
         if (fwd > max_spd) fwd = max_spd;
         if (fwd < 0) fwd = 0;
         if (om > max_trn) om = max_trn;
         if (om < -max_trn) om = -max_trn;
         o.fwd = fwd[14:0];
         o.om = om[15:0];
         o.ex = ex[15:0];
         o.ey = ey[15:0];
         return o;
      endfunction

      function void note_pose(pose_pair_type p);
         pending_cmds.insert(pending_cmds.size(), compute_command(p));
      endfunction

      function void check_command(vel_cmd_type a);
         vel_cmd_type e;
         if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected result fwd=%0d om=%0d ex=%0d ey=%0d",
                     $time, a.fwd, a.om, a.ex, a.ey);
            fails++;
            return;
         end
         e = pending_cmds.pop_front();
         n_checked++;
         if (a.fwd !== e.fwd) begin
            $display("%0t: forward_speed expected %0d actual %0d", $time, e.fwd, a.fwd);
            fails++;
         end
         if (a.om !== e.om) begin
            $display("%0t: turn_rate expected %0d actual %0d", $time, e.om, a.om);
            fails++;
         end
         if (a.ex !== e.ex) begin
            $display("%0t: error_x expected %0d actual %0d", $time, e.ex, a.ex);
            fails++;
         end
         if (a.ey !== e.ey) begin
            $display("%0t: error_y expected %0d actual %0d", $time, e.ey, a.ey);
            fails++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_command = 0;
   logic signed [15:0] req_leader_x = 0, req_leader_y = 0, req_leader_heading = 0;
   logic signed [15:0] req_self_x = 0, req_self_y = 0, req_self_heading = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [14:0] rsp_forward_speed;
   logic signed [15:0] rsp_turn_rate, rsp_error_x, rsp_error_y;
   logic csr_wr_en = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;

   fvc_scoreboard sb = new();
   bit no_idle = 0;
   bit long_hold = 0;
   int n_sent = 0;

   formation_velocity_command DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Note accepted poses, check accepted commands
   always @(posedge clock) begin
      pose_pair_type p;
      vel_cmd_type a;
      if (!reset && req_valid && !req_stall) begin
         p.cmd = req_command; p.lx = req_leader_x; p.ly = req_leader_y;
         p.lh = req_leader_heading; p.sx = req_self_x; p.sy = req_self_y;
         p.sh = req_self_heading;
         sb.note_pose(p);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         a.fwd = rsp_forward_speed; a.om = rsp_turn_rate;
         a.ex = rsp_error_x; a.ey = rsp_error_y;
         sb.check_command(a);
      end
   end

   // Watchdog: cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stall per result, one long hold on request
   initial begin
      int k;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         k = no_idle ? 0 : $urandom_range(0, 15);
         if (k != 0) begin
            rsp_stall <= 1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !long_hold);
      end
   end

   task automatic send_pose(pose_pair_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= p.cmd;
      req_leader_x <= p.lx; req_leader_y <= p.ly; req_leader_heading <= p.lh;
      req_self_x <= p.sx; req_self_y <= p.sy; req_self_heading <= p.sh;
      do @(posedge clock); while (req_stall);
      n_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending_cmds.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Write one register, then lower the write enable again
   task automatic write_csr(logic [2:0] idx, logic [15:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [15:0] g, logic [15:0] b, logic [15:0] l, logic [15:0] kd,
                            logic [15:0] ms, logic [15:0] mt, logic [15:0] rc);
      write_csr(CSR_GAIN, g);
      write_csr(CSR_BACK_OFFSET, b);
      write_csr(CSR_LEFT_OFFSET, l);
      write_csr(CSR_KEEP_DISTANCE, kd);
      write_csr(CSR_MAX_SPEED, ms);
      write_csr(CSR_MAX_TURN, mt);
      write_csr(CSR_OFFSET_RECIP, rc);
      @(posedge clock);
   endtask

   function automatic pose_pair_type make_pose(logic c, int lx, int ly, int lh,
                                               int sx, int sy, int sh);
      pose_pair_type p;
      p.cmd = c; p.lx = 16'(lx); p.ly = 16'(ly); p.lh = 16'(lh);
      p.sx = 16'(sx); p.sy = 16'(sy); p.sh = 16'(sh);
      return p;
   endfunction

   // Mostly nearby poses, some fully random
   function automatic pose_pair_type rand_pose();
      pose_pair_type p;
      int span;
      p.cmd = 1'($urandom_range(0, 1));
      p.lh = 16'($urandom); p.sh = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         p.lx = 16'($urandom); p.ly = 16'($urandom);
         p.sx = 16'($urandom); p.sy = 16'($urandom);
      end else begin
         span = (1 << $urandom_range(2, 14));
         p.lx = 16'(int'($urandom_range(0, 16000)) - 8000);
         p.ly = 16'(int'($urandom_range(0, 16000)) - 8000);
         p.sx = 16'(int'(p.lx) + int'($urandom_range(0, 2 * span)) - span);
         p.sy = 16'(int'(p.ly) + int'($urandom_range(0, 2 * span)) - span);
         if ($urandom_range(0, 15) == 0) begin
            p.sx = p.lx; p.sy = p.ly;
         end
      end
      return p;
   endfunction

   task automatic random_burst(int n);
      repeat (n) send_pose(rand_pose());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, both modes, coincident poses, reversing target
      send_pose(make_pose(0, 0, 0, 0, 0, 0, 0));
      send_pose(make_pose(0, 32767, 32767, 16384, -32768, -32768, 0));
      send_pose(make_pose(0, -32768, -32768, -32768, 32767, 32767, -32768));
      send_pose(make_pose(0, 4096, 0, 0, 8192, 0, 0));
      send_pose(make_pose(0, 0, 0, -16384, 0, 0, 16384));
      send_pose(make_pose(0, -8192, 4096, 8192, 0, 0, -1));
      send_pose(make_pose(0, 100, -100, 32767, -100, 100, 1));
      send_pose(make_pose(1, 0, 0, 0, 0, 0, 0));
      send_pose(make_pose(1, 1234, -4321, 5, 1234, -4321, 77));
      send_pose(make_pose(1, 32767, 32767, 0, -32768, -32768, 0));
      send_pose(make_pose(1, -32768, 32767, 0, 32767, -32768, 8192));
      send_pose(make_pose(1, 8192, 0, 0, 0, 0, -32768));
      send_pose(make_pose(1, 1, 0, 0, 0, 0, 0));
      send_pose(make_pose(1, 0, -3000, 0, 0, 0, -16384));
      send_pose(make_pose(1, 3000, 3000, 0, 0, 0, 8192));
      send_pose(make_pose(0, 20000, -20000, 12345, -20000, 20000, 23456));
      drain();

      // Upper extremes, plus a write to an unmapped index
      write_all(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
      write_csr(CSR_UNMAPPED, 16'h1234);
      send_pose(make_pose(0, 0, 0, 0, 0, 0, 0));
      send_pose(make_pose(1, 0, 0, 0, 0, 0, 0));
      random_burst(150);
      drain();

      // Lower extremes
      write_all(16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_burst(100);
      drain();

      // Defaults back; back-to-back with receiver held off to fill the pipeline
      write_all(16'd4096, 16'd1638, 16'd2867, 16'd3277, 16'd2048, 16'd7373, 16'd20480);
      no_idle = 1;
      long_hold = 1;
      random_burst(150);
      no_idle = 0;
      drain();

      // Random settings
      repeat (4) begin
         write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
         random_burst(120);
         drain();
      end
      no_idle = 1;
      random_burst(60);
      no_idle = 0;
      drain();

      $display("Sent %0d pose pairs over eight register settings; %0d commands checked.",
               n_sent, sb.n_checked);
      if (sb.fails == 0 && sb.pending_cmds.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ formation_velocity_command.f @@
sv/fvc_pkg.sv
sv/formation_velocity_command.sv
sv/fvc_checker.sv
test/tb_formation_velocity_command.sv
